>>> rtl/core/lltab_pkg.sv
// ----------------------------------------------------------------------------
// lltab_pkg: shared types and constants of the linear list table
//
// Command and status codes, the item structs of both channels and the
// control bundle that the sequencer broadcasts to the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package lltab_pkg;

  // Fixed field widths of the channels
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned FILL_W = 11;

  // Default table depth
  localparam int unsigned DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_MTF    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } out_item_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    logic             apply;  // commit the update of the current item
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
  } ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/lltab_cell.sv
// ----------------------------------------------------------------------------
// lltab_cell: one entry of the linear list table
//
// Holds one key, compares it against the broadcast key every cycle and, on
// an update, loads the key or the entry of a neighbor cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lltab_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 10,
  parameter int unsigned CW  = 11
) (
  input  wire                             clk_i,
  input  wire lltab_pkg::ctl_t            ctl_i,
  input  wire [AW-1:0]                    pos_i,
  input  wire [CW-1:0]                    held_i,
  input  wire [lltab_pkg::KEY_W-1:0]      prev_entry_i,
  input  wire [lltab_pkg::KEY_W-1:0]      next_entry_i,
  output logic [lltab_pkg::KEY_W-1:0]     entry_o,
  output logic                            match_o
);

  localparam logic [AW-1:0] IDX_A = AW'(IDX);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [lltab_pkg::KEY_W-1:0] entry_q, entry_d;
  logic                        match_q, match_d;
  logic                        live;

  // only entries below the fill count take part
  assign live    = (IDX_C < held_i);
  assign match_d = live && (entry_q == ctl_i.key);

  // next entry value
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.apply) begin
      case (ctl_i.cmd)
        lltab_pkg::CMD_INSERT: begin
          if (IDX_C == held_i) entry_d = ctl_i.key;
        end
        lltab_pkg::CMD_DELETE: begin
          // close the gap: take the entry above
          if (IDX_A >= pos_i) entry_d = next_entry_i;
        end
        lltab_pkg::CMD_MTF: begin
          // the moved entry equals the key; the ones ahead shift up
          if (IDX == 0) begin
            entry_d = ctl_i.key;
          end else if (IDX_A <= pos_i) begin
            entry_d = prev_entry_i;
          end
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

>>> rtl/core/lltab_find.sv
// ----------------------------------------------------------------------------
// lltab_find: registered first-match tree
//
// Reduces the match flags of all cells to the lowest matching index, one
// register level per tree level.
// ----------------------------------------------------------------------------
`default_nettype none

module lltab_find #(
  parameter int unsigned DEPTH = lltab_pkg::DEPTH_DEF
) (
  input  wire                        clk_i,
  input  wire [DEPTH-1:0]            match_i,
  output logic                       found_o,
  output logic [$clog2(DEPTH)-1:0]   index_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned N  = 1 << AW;

  // heap numbering: nodes 1..N-1 registered, leaves N..2N-1 from the cells
  logic          any_q [1:N-1];
  logic          any_d [1:N-1];
  logic [AW-1:0] idx_q [1:N-1];
  logic [AW-1:0] idx_d [1:N-1];
  logic          lvl_any [1:2*N-1];
  logic [AW-1:0] lvl_idx [1:2*N-1];

  // gather nodes and leaves
  always_comb begin
    for (int k = 1; k < N; k++) begin
      lvl_any[k] = any_q[k];
      lvl_idx[k] = idx_q[k];
    end
    for (int k = N; k < 2 * N; k++) begin
      lvl_any[k] = 1'b0;
      if (k - N < DEPTH) lvl_any[k] = match_i[k-N];
      lvl_idx[k] = AW'(k - N);
    end
  end

  // each node keeps the lower matching child
  always_comb begin
    for (int k = 1; k < N; k++) begin
      any_d[k] = lvl_any[2*k] | lvl_any[2*k+1];
      idx_d[k] = lvl_any[2*k] ? lvl_idx[2*k] : lvl_idx[2*k+1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k < N; k++) begin
      any_q[k] <= any_d[k];
      idx_q[k] <= idx_d[k];
    end
  end

  assign found_o = any_q[1];
  assign index_o = idx_q[1];

endmodule

`default_nettype wire

>>> rtl/core/linear_list_table.sv
// ----------------------------------------------------------------------------
// linear_list_table: unsorted key list with search and move to front
//
// Keeps up to DEPTH keys in a row of cells plus a fill count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item {cmd, key}. The
//   output channel out_valid_o/out_ready_i returns exactly one item
//   {status, position, fill_count} per input item, in order.
//   Insert: after accept the sequencer goes straight to the result state,
//   which fills the output register. Delete, search and move to front:
//   every cell compares its key in parallel, then a registered first-match
//   tree of AW = clog2(DEPTH) levels finds the lowest hit, while the
//   sequencer counts through its search state before the result state.
//   The shift of the list itself is done by all cells at once.
//   One item is in flight at a time. in_ready_o is high only while idle.
//   If the receiver stalls, the finished item waits in the output register
//   and the next result, with its list update, waits until that is taken.
//   Reset empties the list (fill count 0); entry contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_list_table #(
  parameter int unsigned DEPTH = lltab_pkg::DEPTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire lltab_pkg::in_item_t in_item_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output lltab_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned LVL   = AW;
  localparam int unsigned CNT_W = $clog2(LVL + 1);
  localparam logic [CW-1:0]    FULL_C  = CW'(DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(LVL);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_RES
  } state_e;

  state_e                         state_q, state_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [CW-1:0]                  held_q, held_d;
  logic                           out_valid_q, out_valid_d;
  lltab_pkg::out_item_t           out_item_q, out_item_d;
  lltab_pkg::cmd_e                cmd_q;
  logic [lltab_pkg::KEY_W-1:0]    key_q;

  logic                           accept;
  logic                           out_free;
  logic                           found;
  logic [AW-1:0]                  hit_idx;
  logic                           commit;
  lltab_pkg::ctl_t                ctl;
  logic [lltab_pkg::KEY_W-1:0]    entry_w [DEPTH];
  logic [DEPTH-1:0]               match_w;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // captured item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_item_i.cmd;
      key_q <= in_item_i.key;
    end
  end

  // sequencer and result register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    commit      = 1'b0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d   = '0;
          state_d = (in_item_i.cmd == lltab_pkg::CMD_INSERT) ? S_RES : S_SRCH;
        end
      end
      S_SRCH: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_C) state_d = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_item_d.status   = lltab_pkg::ST_MISS;
          out_item_d.position = '0;
          if (cmd_q == lltab_pkg::CMD_INSERT) begin
            if (held_q == FULL_C) begin
              out_item_d.status = lltab_pkg::ST_FULL;
            end else begin
              commit              = 1'b1;
              out_item_d.status   = lltab_pkg::ST_OK;
              out_item_d.position = lltab_pkg::POS_W'(held_q);
              held_d              = held_q + 1'b1;
            end
          end else if (found) begin
            commit              = 1'b1;
            out_item_d.status   = lltab_pkg::ST_OK;
            out_item_d.position = lltab_pkg::POS_W'(hit_idx);
            if (cmd_q == lltab_pkg::CMD_DELETE) held_d = held_q - 1'b1;
          end
          out_item_d.fill_count = lltab_pkg::FILL_W'(held_d);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // broadcast to the cells
  assign ctl.apply = commit;
  assign ctl.cmd   = cmd_q;
  assign ctl.key   = key_q;

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [lltab_pkg::KEY_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = key_q;
    end else begin : g_prev
      assign prev_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = entry_w[i];
    end else begin : g_next
      assign next_w = entry_w[i+1];
    end
    lltab_cell #(
      .IDX (i),
      .AW  (AW),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .pos_i        (hit_idx),
      .held_i       (held_q),
      .prev_entry_i (prev_w),
      .next_entry_i (next_w),
      .entry_o      (entry_w[i]),
      .match_o      (match_w[i])
    );
  end

  // lowest matching index
  lltab_find #(
    .DEPTH (DEPTH)
  ) u_find (
    .clk_i   (clk_i),
    .match_i (match_w),
    .found_o (found),
    .index_o (hit_idx)
  );

  // checks
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= FULL_C)
    else $error("fill count above depth");

  a_out_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RES))
    else $error("result raised outside result state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("sequencer idle after accepting an item");

  a_miss_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == lltab_pkg::ST_OK
                     || out_item_o.position == '0))
    else $error("nonzero position on failed operation");

  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_RES) |=> $stable(held_q))
    else $error("fill count changed outside result state");

endmodule

`default_nettype wire
